>>> hdl/esfc_pkg.sv
// Shared types and constants of the electron sampling-fraction cut.
`default_nettype none

package esfc_pkg;

    localparam int X_W       = 16;   // hit energies, momentum and fraction
    localparam int COEF_W    = 32;   // coefficient word, signed Q12.20
    localparam int COEF_FRAC = 20;
    localparam int CURVE_W   = 40;   // saturated curve value, Q20.20
    localparam int ROW_MAX_W = 4;    // enough for sixteen sectors
    localparam int WORDS_ROW = 6;    // mean a,b,c then sigma a,b,c
    localparam int CMP_W     = 64;

    localparam logic signed [15:0] PID_ELECTRON = 16'sd11;
    localparam logic signed [1:0]  CHARGE_NEG   = -2'sd1;

    typedef enum logic [1:0] {
        REG_INTERVAL_E = 2'd0,
        REG_INTERVAL_M = 2'd1,
        REG_LOOSE      = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        CMD_CLASSIFY = 1'b0,
        CMD_LOAD     = 1'b1
    } cmd_t;

    typedef logic [WORDS_ROW-1:0][COEF_W-1:0] coef_row_t;

    // Per-beat context that travels beside the reciprocal pipeline
    typedef struct packed {
        cmd_t                 cmd;
        logic [ROW_MAX_W-1:0] row;
        logic                 sec_ok;
        logic [X_W-1:0]       sf;
        logic                 zero_e;    // pcal energy is zero
        logic                 zero_m;    // momentum is zero
        logic                 nz_ok;     // pcal, ecin and fraction all non-zero
        logic                 pc_ok;     // PID and charge match an electron
        logic                 sum_ok;
        logic                 tsel;
        logic                 idx_ok;
        logic [2:0]           lane;
        logic [COEF_W-1:0]    cval;
    } sband_t;

endpackage

`default_nettype wire

>>> hdl/electron_sampling_fraction_cut.sv
// Electron sampling-fraction cut, fully pipelined: one beat in per cycle while no result is held,
// one decision out per classify beat. The reciprocal units have NB = FRAC_BITS+41 divider
// stages and P = ceil(NB/2) square-root stages; stages A to D and the output register follow.
// Throughput: one beat per cycle, loads and classifies alike; the whole pipe holds on a
// stalled result. rst_n clears valid bits and the band/mode registers (3.5 sigma, strict);
// coefficient memories are not cleared and must be loaded before use.
`default_nettype none

module electron_sampling_fraction_cut #(
    parameter int NUM_SECTORS = 6,
    parameter int FRAC_BITS   = 12
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // sector[2:0] pcal_energy[18:3] ecin_energy[34:19] sampling_fraction[50:35]
    // momentum[66:51] pid_code[82:67] charge[84:83] table_select[85]
    // coeff_index[91:86] coeff_value[123:92], zero fill above
    input  wire logic [127:0] s_tdata,
    input  wire logic [0:0]   s_tuser,    // command[0]
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // is_electron[0] pass_energy_band[1] pass_momentum_band[2] pass_energy_sum[3]
    output logic [7:0]        m_tdata,
    // configuration
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_wdata
);
    import esfc_pkg::*;

    localparam int NB    = FRAC_BITS + 2*COEF_FRAC + 1;
    localparam int P     = (NB + 1) / 2;
    localparam int REC_W = NB - COEF_FRAC;
    localparam int LM    = NB + P;                 // reciprocal pipe depth
    localparam int ROW_W = (NUM_SECTORS > 1) ? $clog2(NUM_SECTORS) : 1;
    localparam int PW    = COEF_W + REC_W + 1;     // product width
    localparam int SW    = PW + 2;                 // curve sum width
    localparam int DW    = CURVE_W + 2;            // fraction minus mean
    localparam int SF_SH = COEF_FRAC - FRAC_BITS;
    localparam logic [31:0] P_HIGH = 32'(9) << (FRAC_BITS - 1);   // 4.5 GeV
    localparam logic signed [SW-1:0] SAT_HI = SW'({1'b0, {(CURVE_W-1){1'b1}}});
    localparam logic signed [SW-1:0] SAT_LO = -SW'({1'b1, {(CURVE_W-1){1'b0}}});

    // configuration registers
    logic [15:0] int_e_reg, int_m_reg;
    logic        loose_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_e_reg <= 16'd14336;
            int_m_reg <= 16'd14336;
            loose_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INTERVAL_E: int_e_reg <= cfg_wdata;
                REG_INTERVAL_M: int_m_reg <= cfg_wdata;
                REG_LOOSE:      loose_reg <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    // input field split
    logic [2:0]         in_sector;
    logic [X_W-1:0]     in_pcal, in_ecin, in_sf, in_mom;
    logic signed [15:0] in_pid;
    logic signed [1:0]  in_charge;
    logic [5:0]         in_idx;

    assign in_sector = s_tdata[2:0];
    assign in_pcal   = s_tdata[18:3];
    assign in_ecin   = s_tdata[34:19];
    assign in_sf     = s_tdata[50:35];
    assign in_mom    = s_tdata[66:51];
    assign in_pid    = s_tdata[82:67];
    assign in_charge = s_tdata[84:83];
    assign in_idx    = s_tdata[91:86];

    // whole pipe moves unless a result is held
    logic adv;
    logic out_v_reg;
    logic [3:0] out_d_reg;

    assign adv      = !out_v_reg || m_tready;
    assign s_tready = adv;

    // entry context
    sband_t sb_in;
    logic [19:0] e_sum5;

    always_comb
    begin
        sb_in        = '0;
        sb_in.cmd    = cmd_t'(s_tuser[0]);
        sb_in.sec_ok = (in_sector != 3'd0) && (32'(in_sector) <= 32'(NUM_SECTORS));
        sb_in.row    = sb_in.sec_ok ? ROW_MAX_W'(in_sector - 3'd1) : '0;
        sb_in.sf     = in_sf;
        sb_in.zero_e = (in_pcal == '0);
        sb_in.zero_m = (in_mom == '0);
        sb_in.nz_ok  = (in_pcal != '0) && (in_ecin != '0) && (in_sf != '0);
        sb_in.pc_ok  = (in_pid == PID_ELECTRON) && (in_charge == CHARGE_NEG);
        e_sum5       = 20'(5) * (20'(in_pcal) + 20'(in_ecin));
        sb_in.sum_ok = (32'(in_mom) < P_HIGH) || (e_sum5 >= 20'(in_mom));
        sb_in.tsel   = s_tdata[85];
        sb_in.cval   = s_tdata[123:92];
        // coefficient index split into row and word, one compare per row
        for (int r = 0; r < NUM_SECTORS; r++)
        begin
            if ((7'(in_idx) >= 7'(6*r)) && (7'(in_idx) < 7'(6*r + 6)))
            begin
                sb_in.idx_ok = 1'b1;
                if (sb_in.cmd == CMD_LOAD)
                    sb_in.row = ROW_MAX_W'(r);
                sb_in.lane = 3'(7'(in_idx) - 7'(6*r));
            end
        end
    end

    // reciprocal units, energy and momentum
    logic [P-1:0]     rsq_e, rsq_m;
    logic [REC_W-1:0] rec_e, rec_m;

    esfc_recip #(.FRAC_BITS(FRAC_BITS)) u_recip_e (
        .clk(clk), .en(adv), .x(in_pcal), .rsq(rsq_e), .rec(rec_e)
    );
    esfc_recip #(.FRAC_BITS(FRAC_BITS)) u_recip_m (
        .clk(clk), .en(adv), .x(in_mom), .rsq(rsq_m), .rec(rec_m)
    );

    // context delay line matching the reciprocal units
    logic   v_pipe_reg [LM];
    sband_t sb_pipe_reg [LM];

    for (genvar s = 0; s < LM; s++) begin : g_sb
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_pipe_reg[s] <= 1'b0;
            else if (adv)
                v_pipe_reg[s] <= (s == 0) ? s_tvalid : v_pipe_reg[(s == 0) ? 0 : s-1];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
                sb_pipe_reg[s] <= (s == 0) ? sb_in : sb_pipe_reg[(s == 0) ? 0 : s-1];
        end
    end

    sband_t sb_l;
    logic   v_l;
    assign sb_l = sb_pipe_reg[LM-1];
    assign v_l  = v_pipe_reg[LM-1];

    // coefficient memories: one row per sector, word write enables, registered read.
    // Loads write here in stream order, so a classify always sees every earlier load.
    coef_row_t mem_e [NUM_SECTORS];
    coef_row_t mem_m [NUM_SECTORS];
    coef_row_t rd_e_reg, rd_m_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (v_l && sb_l.cmd == CMD_LOAD && sb_l.idx_ok)
            begin
                if (!sb_l.tsel)
                    mem_e[sb_l.row[ROW_W-1:0]][sb_l.lane] <= sb_l.cval;
                else
                    mem_m[sb_l.row[ROW_W-1:0]][sb_l.lane] <= sb_l.cval;
            end
            rd_e_reg <= mem_e[sb_l.row[ROW_W-1:0]];
            rd_m_reg <= mem_m[sb_l.row[ROW_W-1:0]];
        end
    end

    // stage A: memory data plus reciprocals
    logic             a_v_reg;
    sband_t           a_sb_reg;
    logic [P-1:0]     a_rsq_reg [2];
    logic [REC_W-1:0] a_rec_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (adv)
            a_v_reg <= v_l && (sb_l.cmd == CMD_CLASSIFY);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_sb_reg     <= sb_l;
            a_rsq_reg[0] <= rsq_e;
            a_rsq_reg[1] <= rsq_m;
            a_rec_reg[0] <= rec_e;
            a_rec_reg[1] <= rec_m;
        end
    end

    // stage B: b/sqrt(x) and c/x products; index [table][curve], curve 0 mean, 1 sigma
    logic                     b_v_reg;
    sband_t                   b_sb_reg;
    logic signed [PW-1:0]     b_pb_reg [2][2];
    logic signed [PW-1:0]     b_pc_reg [2][2];
    logic signed [COEF_W-1:0] b_a_reg  [2][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else if (adv)
            b_v_reg <= a_v_reg;
    end

    for (genvar t = 0; t < 2; t++) begin : g_tab
        for (genvar c = 0; c < 2; c++) begin : g_crv
            coef_row_t row;
            assign row = (t == 0) ? rd_e_reg : rd_m_reg;
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    b_a_reg[t][c]  <= $signed(row[3*c]);
                    b_pb_reg[t][c] <= $signed(row[3*c+1]) * $signed({1'b0, a_rsq_reg[t]});
                    b_pc_reg[t][c] <= $signed(row[3*c+2]) * $signed({1'b0, a_rec_reg[t]});
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            b_sb_reg <= a_sb_reg;
    end

    // stage C: curve sum, floored terms, saturated to Q20.20
    logic                      c_v_reg;
    sband_t                    c_sb_reg;
    logic signed [CURVE_W-1:0] c_f_reg [2][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else if (adv)
            c_v_reg <= b_v_reg;
    end

    for (genvar t = 0; t < 2; t++) begin : g_sum_t
        for (genvar c = 0; c < 2; c++) begin : g_sum_c
            logic signed [SW-1:0] f;
            assign f = SW'(b_a_reg[t][c]) + SW'(b_pb_reg[t][c] >>> COEF_FRAC)
                     + SW'(b_pc_reg[t][c] >>> COEF_FRAC);
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (f > SAT_HI)
                        c_f_reg[t][c] <= SAT_HI[CURVE_W-1:0];
                    else if (f < SAT_LO)
                        c_f_reg[t][c] <= SAT_LO[CURVE_W-1:0];
                    else
                        c_f_reg[t][c] <= f[CURVE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            c_sb_reg <= b_sb_reg;
    end

    // stage D: |sf - mean| scaled against interval * sigma
    logic                    d_v_reg;
    sband_t                  d_sb_reg;
    logic signed [CMP_W-1:0] d_lhs_reg [2];
    logic signed [CMP_W-1:0] d_rhs_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_v_reg <= 1'b0;
        else if (adv)
            d_v_reg <= c_v_reg;
    end

    for (genvar t = 0; t < 2; t++) begin : g_band
        logic signed [DW-1:0] dd;
        logic [DW-1:0]        ad;
        logic [15:0]          ivl;
        assign ivl = (t == 0) ? int_e_reg : int_m_reg;
        assign dd  = $signed(DW'(c_sb_reg.sf) << SF_SH) - DW'(c_f_reg[t][0]);
        assign ad  = dd[DW-1] ? DW'(-dd) : DW'(dd);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d_lhs_reg[t] <= $signed(CMP_W'(ad) << FRAC_BITS);
                d_rhs_reg[t] <= $signed({1'b0, ivl}) * c_f_reg[t][1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            d_sb_reg <= c_sb_reg;
    end

    // decision and output register
    logic e_ok, m_ok, elec;

    always_comb
    begin
        e_ok = d_sb_reg.sec_ok && !d_sb_reg.zero_e && (d_lhs_reg[0] <= d_rhs_reg[0]);
        m_ok = d_sb_reg.sec_ok && !d_sb_reg.zero_m && (d_lhs_reg[1] <= d_rhs_reg[1]);
        if (loose_reg)
            elec = d_sb_reg.pc_ok && e_ok;
        else
            elec = d_sb_reg.nz_ok && d_sb_reg.pc_ok && e_ok && m_ok && d_sb_reg.sum_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= d_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_d_reg <= {d_sb_reg.sum_ok, m_ok, e_ok, elec};
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {4'b0, out_d_reg};

endmodule

`default_nettype wire

>>> hdl/esfc_recip.sv
// Pipelined 1/x and 1/sqrt(x) in Q.20: restoring divider then digit-pair square root.
`default_nettype none

module esfc_recip #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic                                               clk,
    input  wire logic                                               en,
    input  wire logic [esfc_pkg::X_W-1:0]                           x,
    output logic [(FRAC_BITS+2*esfc_pkg::COEF_FRAC+2)/2-1:0]        rsq,
    output logic [FRAC_BITS+esfc_pkg::COEF_FRAC:0]                  rec
);
    import esfc_pkg::*;

    localparam int NB    = FRAC_BITS + 2*COEF_FRAC + 1;  // quotient bits of 2^(F+40)/x
    localparam int P     = (NB + 1) / 2;                 // root bits
    localparam int REC_W = NB - COEF_FRAC;

    // divider stages
    logic [X_W:0]   drem_reg [NB];
    logic [NB-1:0]  dq_reg   [NB];
    logic [X_W-1:0] dx_reg   [NB];

    // square-root stages
    logic [2*P-1:0]   sv_reg   [P];
    logic [P-1:0]     root_reg [P];
    logic [P+1:0]     srem_reg [P];
    logic [REC_W-1:0] srec_reg [P];

    for (genvar i = 0; i < NB; i++) begin : g_div
        localparam logic DBIT = (i == 0);
        logic [X_W:0]   rprev, rin;
        logic [NB-1:0]  qprev;
        logic [X_W-1:0] xprev;
        logic           ge;
        if (i == 0) begin : g_first
            assign rprev = '0;
            assign qprev = '0;
            assign xprev = x;
        end
        else begin : g_next
            assign rprev = drem_reg[i-1];
            assign qprev = dq_reg[i-1];
            assign xprev = dx_reg[i-1];
        end
        assign rin = {rprev[X_W-1:0], DBIT};
        assign ge  = rin >= {1'b0, xprev};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                drem_reg[i] <= ge ? rin - {1'b0, xprev} : rin;
                dq_reg[i]   <= {qprev[NB-2:0], ge};
                dx_reg[i]   <= xprev;
            end
        end
    end

    for (genvar k = 0; k < P; k++) begin : g_sqrt
        logic [2*P-1:0]   vprev;
        logic [P-1:0]     rtprev;
        logic [P+1:0]     rmprev, rin, trial;
        logic [REC_W-1:0] rcprev;
        logic             ge;
        if (k == 0) begin : g_first
            assign vprev  = (2*P)'(dq_reg[NB-1]);
            assign rtprev = '0;
            assign rmprev = '0;
            assign rcprev = dq_reg[NB-1][NB-1:COEF_FRAC];
        end
        else begin : g_next
            assign vprev  = sv_reg[k-1];
            assign rtprev = root_reg[k-1];
            assign rmprev = srem_reg[k-1];
            assign rcprev = srec_reg[k-1];
        end
        assign rin   = {rmprev[P-1:0], vprev[2*P-1-2*k -: 2]};
        assign trial = {rtprev, 2'b01};
        assign ge    = rin >= trial;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sv_reg[k]   <= vprev;
                root_reg[k] <= {rtprev[P-2:0], ge};
                srem_reg[k] <= ge ? rin - trial : rin;
                srec_reg[k] <= rcprev;
            end
        end
    end

    assign rsq = root_reg[P-1];
    assign rec = srec_reg[P-1];

endmodule

`default_nettype wire

>>> hdl/esfc_checker.sv
// Port-level checks of the sampling-fraction cut, bound to the top level.
`default_nettype none

module esfc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata
);

    // a held result keeps its flags
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // input is refused only while a result waits
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // an electron always passed the energy band
    a_elec: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && !m_tdata[1]))
        else $error("electron without energy band pass");

    // no result during reset
    a_rst: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid in reset");

endmodule

bind electron_sampling_fraction_cut esfc_checker u_esfc_checker (
    .clk(clk), .rst_n(rst_n), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

`default_nettype wire

>>> tb/electron_sampling_fraction_cut_test.sv
// Self-checking bench for the electron sampling-fraction cut: predictor, scoreboard, stimulus.
`timescale 1ns / 100ps

import esfc_pkg::*;

// Expected decision of one classify beat
typedef struct packed {
    logic is_elec;
    logic e_band;
    logic m_band;
    logic e_sum;
} cut_result_t;

// Holds its own copy of the tables and registers, predicts each decision and checks it
class cut_scoreboard;
    logic [31:0] e_tab [36];
    logic [31:0] m_tab [36];
    logic [15:0] int_e;
    logic [15:0] int_m;
    logic        loose;
    cut_result_t pending[$];
    int          n_err;
    int          n_checked;
    int          n_elec;
    int          n_load;

    function new();
        int i;
        for (i = 0; i < 36; i++)
        begin
            e_tab[i] = '0;
            m_tab[i] = '0;
        end
        int_e = 16'd14336;
        int_m = 16'd14336;
        loose = 1'b0;
        pending = {};
        n_err = 0;
        n_checked = 0;
        n_elec = 0;
        n_load = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [15:0] val);
        case (idx)
            REG_INTERVAL_E: int_e = val;
            REG_INTERVAL_M: int_m = val;
            REG_LOOSE:      loose = val[0];
            default: ;
        endcase
    endfunction

    // floor(sqrt(v)) bit by bit
    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // a + b*rsq + c*rec, each product floored to Q.20, saturated to 40 bits
    function automatic logic signed [127:0] curve(logic [31:0] a, logic [31:0] b,
                                                  logic [31:0] c, logic [63:0] rsq,
                                                  logic [63:0] rec);
        logic signed [127:0] f;
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< 39) - 1;
        lo = -(128'sd1 <<< 39);
        f = 128'(signed'(a))
          + ((128'(signed'(b)) * signed'({64'd0, rsq})) >>> 20)
          + ((128'(signed'(c)) * signed'({64'd0, rec})) >>> 20);
        if (f > hi) f = hi;
        if (f < lo) f = lo;
        return f;
    endfunction

    function automatic logic in_band(bit mtab, int base, logic [15:0] x, logic [15:0] sf,
                                     logic [15:0] ival);
        logic [63:0] rec;
        logic [63:0] rsq;
        logic signed [127:0] mean;
        logic signed [127:0] sig;
        logic signed [127:0] d;
        logic [31:0] w [6];
        int k;
        if (x == 0) return 1'b0;
        for (k = 0; k < 6; k++) w[k] = mtab ? m_tab[base + k] : e_tab[base + k];
        rec = (64'd1 << 32) / x;
        rsq = root_floor((64'd1 << 52) / x);
        mean = curve(w[0], w[1], w[2], rsq, rec);
        sig = curve(w[3], w[4], w[5], rsq, rec);
        d = (128'sd1 * sf) * 256 - mean;
        if (d < 0) d = -d;
        return (d * 4096) <= (signed'({112'd0, ival}) * sig);
    endfunction

    // Notes an accepted input beat
    function void take_beat(cmd_t cmd, logic [127:0] d);
        logic [2:0]  sec;
        logic [15:0] pcal, ecin, sf, mom;
        logic        pc_ok;
        logic [5:0]  idx;
        cut_result_t r;
        sec = d[2:0];
        pcal = d[18:3];
        ecin = d[34:19];
        sf = d[50:35];
        mom = d[66:51];
        idx = d[91:86];
        if (cmd == CMD_LOAD)
        begin
            n_load++;
            if (idx < 36)
            begin
                if (d[85]) m_tab[idx] = d[123:92];
                else e_tab[idx] = d[123:92];
            end
            return;
        end
        pc_ok = (signed'(d[82:67]) == PID_ELECTRON) && (signed'(d[84:83]) == CHARGE_NEG);
        r.e_band = 1'b0;
        r.m_band = 1'b0;
        if (sec >= 1 && sec <= 6)
        begin
            r.e_band = in_band(1'b0, (sec - 1) * 6, pcal, sf, int_e);
            r.m_band = in_band(1'b1, (sec - 1) * 6, mom, sf, int_m);
        end
        r.e_sum = (mom < 16'd18432) || (5 * (32'(pcal) + 32'(ecin)) >= 32'(mom));
        if (loose)
            r.is_elec = pc_ok && r.e_band;
        else
            r.is_elec = pcal != 0 && sf != 0 && ecin != 0 && pc_ok && r.e_band
                      && r.m_band && r.e_sum;
        pending.push_back(r);
    endfunction

    // Checks one result beat against the oldest expectation
    function void check_result(logic [7:0] d);
        cut_result_t exp_r;
        cut_result_t got;
        got = {d[0], d[1], d[2], d[3]};
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result beat %h", $time, d);
            n_err++;
            return;
        end
        exp_r = pending.pop_front();
        n_checked++;
        if (got.is_elec) n_elec++;
        if (got.is_elec !== exp_r.is_elec)
        begin
            $display("%0t: is_electron exp %b got %b", $time, exp_r.is_elec, got.is_elec);
            n_err++;
        end
        if (got.e_band !== exp_r.e_band)
        begin
            $display("%0t: pass_energy_band exp %b got %b", $time, exp_r.e_band, got.e_band);
            n_err++;
        end
        if (got.m_band !== exp_r.m_band)
        begin
            $display("%0t: pass_momentum_band exp %b got %b", $time, exp_r.m_band,
                     got.m_band);
            n_err++;
        end
        if (got.e_sum !== exp_r.e_sum)
        begin
            $display("%0t: pass_energy_sum exp %b got %b", $time, exp_r.e_sum, got.e_sum);
            n_err++;
        end
    endfunction
endclass

module electron_sampling_fraction_cut_test;

    localparam int LATENCY    = 85;
    localparam int IDLE_LIMIT = 20000;   // well above latency plus the longest stall

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;    // sector, pcal, ecin, fraction, momentum, pid, charge,
                              // table_select, coeff_index, coeff_value; low bits first
    logic [0:0]   s_tuser;    // command
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;    // is_electron, energy band, momentum band, energy sum
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_wdata;

    cut_scoreboard sb;
    bit            drive_done;
    bit            hold_sink;     // long receiver hold-off while the source keeps going
    int            idle_cycles;

    electron_sampling_fraction_cut u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [127:0] pack_hit(logic [2:0] sec, logic [15:0] pcal,
                                              logic [15:0] ecin, logic [15:0] sf,
                                              logic [15:0] mom, logic [15:0] pid,
                                              logic [1:0] chg);
        logic [127:0] d;
        d = '0;
        d[2:0] = sec;
        d[18:3] = pcal;
        d[34:19] = ecin;
        d[50:35] = sf;
        d[66:51] = mom;
        d[82:67] = pid;
        d[84:83] = chg;
        return d;
    endfunction

    // Sends one beat; on a phase with a gap of zero valid stays high into the next beat
    task automatic send_beat(cmd_t cmd, logic [127:0] d);
        int g;
        g = gap_len();
        repeat (g)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= cmd;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.take_beat(cmd, d);
    endtask

    task automatic load_word(bit tsel, logic [5:0] idx, logic [31:0] val);
        logic [127:0] d;
        d = {$urandom(), $urandom(), $urandom(), $urandom()};
        d[127:124] = '0;
        d[85] = tsel;
        d[91:86] = idx;
        d[123:92] = val;
        send_beat(CMD_LOAD, d);
    endtask

    // Random but plausible curve: mean near 0.25, sigma small and positive
    task automatic load_sector(int sec);
        int k;
        int t;
        logic [31:0] v;
        for (t = 0; t < 2; t++)
            for (k = 0; k < 6; k++)
            begin
                case (k)
                    0: v = 32'd262144 + $urandom_range(0, 20000) - 10000;
                    3: v = 32'd10000 + $urandom_range(0, 20000);
                    default: v = $urandom_range(0, 4000) - 2000;
                endcase
                if ($urandom_range(0, 19) == 0) v = $urandom();
                load_word(t[0], 6'((sec - 1) * 6 + k), v);
            end
    endtask

    function automatic logic [15:0] rand_x();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        if (r < 4) return 16'($urandom());
        return 16'($urandom_range(1000, 40000));
    endfunction

    task automatic send_hit(bit well_formed);
        logic [2:0]  sec;
        logic [15:0] pid;
        logic [1:0]  chg;
        logic [15:0] sf;
        sec = well_formed ? 3'($urandom_range(1, 6)) : 3'($urandom());
        pid = (well_formed || $urandom_range(0, 1)) ? 16'd11 : 16'($urandom());
        chg = (well_formed || $urandom_range(0, 1)) ? 2'b11 : 2'($urandom());
        // fraction mostly near the band centre (0.25 = 1024)
        sf = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(700, 1350));
        send_beat(CMD_CLASSIFY, pack_hit(sec, rand_x(), rand_x(), sf, rand_x(), pid, chg));
    endtask

    // Drops valid at once, waits until every decision is in, then lets the pipe drain
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_cfg(cfg_reg_t idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        int s;
        int ph;
        int i;
        logic [15:0] bands [4];
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_CLASSIFY;
        cfg_we = 1'b0;
        cfg_index = REG_INTERVAL_E;
        cfg_wdata = '0;
        drive_done = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every word is written before any classify reads it
        for (s = 1; s <= 6; s++) load_sector(s);
        // out-of-range indexes are dropped, both tables
        load_word(1'b0, 6'd36, 32'h7FFFFFFF);
        load_word(1'b1, 6'd63, 32'h80000000);

        // directed: zero x, zero energies, bad sectors, field extremes, momentum cut
        send_beat(CMD_CLASSIFY, pack_hit(3'd1, 16'd0, 16'd4000, 16'd1024, 16'd8000,
                                         16'd11, 2'b11));
        send_beat(CMD_CLASSIFY, pack_hit(3'd2, 16'd8000, 16'd4000, 16'd1024, 16'd0,
                                         16'd11, 2'b11));
        send_beat(CMD_CLASSIFY, pack_hit(3'd3, 16'd8000, 16'd0, 16'd1024, 16'd8000,
                                         16'd11, 2'b11));
        send_beat(CMD_CLASSIFY, pack_hit(3'd4, 16'd8000, 16'd4000, 16'd0, 16'd8000,
                                         16'd11, 2'b11));
        send_beat(CMD_CLASSIFY, pack_hit(3'd0, 16'd8000, 16'd4000, 16'd1024, 16'd8000,
                                         16'd11, 2'b11));
        send_beat(CMD_CLASSIFY, pack_hit(3'd7, 16'd8000, 16'd4000, 16'd1024, 16'd8000,
                                         16'd11, 2'b11));
        send_beat(CMD_CLASSIFY, pack_hit(3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                         16'h8000, 2'b10));
        send_beat(CMD_CLASSIFY, pack_hit(3'd6, 16'd1, 16'd1, 16'd1, 16'd1,
                                         16'h7FFF, 2'b01));
        send_beat(CMD_CLASSIFY, pack_hit(3'd6, 16'd2000, 16'd1000, 16'd1024, 16'd18432,
                                         16'd11, 2'b11));
        send_beat(CMD_CLASSIFY, pack_hit(3'd6, 16'd1000, 16'd100, 16'd1024, 16'd40000,
                                         16'd11, 2'b00));
        send_beat(CMD_CLASSIFY, pack_hit(3'd1, 16'd12000, 16'd6000, 16'd1024, 16'd18431,
                                         16'hFFF5, 2'b11));

        // phases over register settings, extremes included
        bands[0] = 16'd0;
        bands[1] = 16'hFFFF;
        bands[2] = 16'd14336;
        bands[3] = 16'd4096;
        for (ph = 0; ph < 6; ph++)
        begin
            drain();
            write_cfg(REG_INTERVAL_E, ph < 4 ? bands[ph] : 16'($urandom()));
            write_cfg(REG_INTERVAL_M, ph < 4 ? bands[3 - ph] : 16'($urandom()));
            write_cfg(REG_LOOSE, 16'(ph % 2));
            if (ph == 3) load_sector($urandom_range(1, 6));
            for (i = 0; i < 250; i++)
            begin
                if ($urandom_range(0, 49) == 0)
                    load_word($urandom_range(0, 1), 6'($urandom()), $urandom());
                else
                    send_hit($urandom_range(0, 9) < 8);
            end
        end
        s_tvalid <= 1'b0;
        drive_done = 1;
    end

    // Receiver: random stalls plus one long hold-off early in the run
    initial
    begin
        int g;
        hold_sink = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        repeat (200) @(posedge clk);
        hold_sink = 1;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_sink = 0;
        forever
        begin
            g = gap_len();
            if ($urandom_range(0, 3) == 0) g = 0;
            if (g == 0)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    // Result monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
        else
            idle_cycles <= 0;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_cycles > IDLE_LIMIT)
            begin
                $display("watchdog: nothing accepted for %0d cycles", idle_cycles);
                $display("TB_ERROR");
                $finish;
            end
            if (drive_done && sb.pending.size() == 0)
            begin
                repeat (LATENCY + 20) @(posedge clk);
                if (sb.pending.size() != 0) sb.n_err++;
                $display("covered %0d decisions (%0d electrons) and %0d loads", sb.n_checked,
                         sb.n_elec, sb.n_load);
                $display("six register settings incl. band extremes, strict and loose mode");
                if (sb.n_err == 0)
                    $display("TB_OK");
                else
                    $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule
